[rtl/core/cpt_pkg.sv]
package cpt_pkg;

    // coordinate width; every width below except the limb width follows from it
    localparam int CW = 32;
    // coordinate differences
    localparam int DW = CW + 1;
    // single product of two differences
    localparam int MW = 2 * DW;
    // dot products d1..d6
    localparam int PW = MW + 2;
    // half of a dot product, the operand width of the cross-term multipliers
    localparam int HW = PW / 2;
    // barycentric terms va, vb, vc
    localparam int VW = 2 * PW + 1;
    // numerator and divisor of the final division
    localparam int NW = VW + DW + 2;
    // limb width and limb count of the numerator multipliers
    localparam int LW = 32;
    localparam int NL = (VW + LW - 1) / LW;
    // quotient magnitude bits; larger quotients always saturate
    localparam int QW = DW + 2;
    // doubled numerator plus divisor, unsigned
    localparam int RW = NW + 2;
    // remainder and shifted divisor inside the divider
    localparam int SW = RW + QW;
    // base plus signed quotient before saturation
    localparam int OW = CW + QW + 2;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] dot_t;
    typedef logic signed [VW-1:0] bary_t;
    typedef logic signed [NW-1:0] numer_t;
    typedef logic [2:0] region_t;

    localparam region_t REGION_A  = 3'd0;
    localparam region_t REGION_B  = 3'd1;
    localparam region_t REGION_C  = 3'd2;
    localparam region_t REGION_AB = 3'd3;
    localparam region_t REGION_AC = 3'd4;
    localparam region_t REGION_BC = 3'd5;
    localparam region_t REGION_IN = 3'd6;

    typedef struct packed {
        coord_t vertex_a_x;
        coord_t vertex_a_y;
        coord_t vertex_a_z;
        coord_t vertex_b_x;
        coord_t vertex_b_y;
        coord_t vertex_b_z;
        coord_t vertex_c_x;
        coord_t vertex_c_y;
        coord_t vertex_c_z;
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
    } query_t;

    typedef struct packed {
        coord_t  nearest_x;
        coord_t  nearest_y;
        coord_t  nearest_z;
        region_t region;
        logic    degenerate;
    } result_t;

    // cycles from the accepting edge to the edge that takes the result
    localparam int LATENCY = QW + 12;

endpackage

[rtl/core/closest_point_on_triangle_core.sv]
// Closest point on a 3-D triangle, fully pipelined.
// Throughput: one transaction per cycle; busy is never raised.
// The result passes through the ten arithmetic stages, the one-bit-per-stage divider
// and the output register before done is raised.
// Reset (rst_n low, asynchronous) clears all valid bits; data in flight is dropped.
// The receiver cannot stall; done is a one-cycle strobe.
module closest_point_on_triangle_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cpt_pkg::query_t  query,
    output logic             done,
    output cpt_pkg::result_t result
);
    import cpt_pkg::*;

    coord_t a_in [3];
    coord_t b_in [3];
    coord_t c_in [3];
    coord_t p_in [3];

    assign a_in[0] = query.vertex_a_x;
    assign a_in[1] = query.vertex_a_y;
    assign a_in[2] = query.vertex_a_z;
    assign b_in[0] = query.vertex_b_x;
    assign b_in[1] = query.vertex_b_y;
    assign b_in[2] = query.vertex_b_z;
    assign c_in[0] = query.vertex_c_x;
    assign c_in[1] = query.vertex_c_y;
    assign c_in[2] = query.vertex_c_z;
    assign p_in[0] = query.point_x;
    assign p_in[1] = query.point_y;
    assign p_in[2] = query.point_z;

    assign busy = 1'b0;

    // valid bits of the arithmetic stages
    logic [10:1] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[9:1], start};
        end
    end

    // stage 1: differences
    coord_t a1_reg [3];
    coord_t b1_reg [3];
    coord_t c1_reg [3];
    diff_t  ab1_reg [3];
    diff_t  ac1_reg [3];
    diff_t  bc1_reg [3];
    diff_t  ap1_reg [3];
    diff_t  bp1_reg [3];
    diff_t  cp1_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            a1_reg[k]  <= a_in[k];
            b1_reg[k]  <= b_in[k];
            c1_reg[k]  <= c_in[k];
            ab1_reg[k] <= DW'(b_in[k]) - DW'(a_in[k]);
            ac1_reg[k] <= DW'(c_in[k]) - DW'(a_in[k]);
            bc1_reg[k] <= DW'(c_in[k]) - DW'(b_in[k]);
            ap1_reg[k] <= DW'(p_in[k]) - DW'(a_in[k]);
            bp1_reg[k] <= DW'(p_in[k]) - DW'(b_in[k]);
            cp1_reg[k] <= DW'(p_in[k]) - DW'(c_in[k]);
        end
    end

    // stage 2: the eighteen component products of d1..d6
    logic signed [MW-1:0] pr2_reg [6][3];
    coord_t a2_reg [3];
    coord_t b2_reg [3];
    coord_t c2_reg [3];
    diff_t  ab2_reg [3];
    diff_t  ac2_reg [3];
    diff_t  bc2_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pr2_reg[0][k] <= MW'(ab1_reg[k]) * MW'(ap1_reg[k]);
            pr2_reg[1][k] <= MW'(ac1_reg[k]) * MW'(ap1_reg[k]);
            pr2_reg[2][k] <= MW'(ab1_reg[k]) * MW'(bp1_reg[k]);
            pr2_reg[3][k] <= MW'(ac1_reg[k]) * MW'(bp1_reg[k]);
            pr2_reg[4][k] <= MW'(ab1_reg[k]) * MW'(cp1_reg[k]);
            pr2_reg[5][k] <= MW'(ac1_reg[k]) * MW'(cp1_reg[k]);
            a2_reg[k]  <= a1_reg[k];
            b2_reg[k]  <= b1_reg[k];
            c2_reg[k]  <= c1_reg[k];
            ab2_reg[k] <= ab1_reg[k];
            ac2_reg[k] <= ac1_reg[k];
            bc2_reg[k] <= bc1_reg[k];
        end
    end

    // stage 3: dot products d1..d6 (index 0..5)
    dot_t   d3_reg [6];
    coord_t a3_reg [3];
    coord_t b3_reg [3];
    coord_t c3_reg [3];
    diff_t  ab3_reg [3];
    diff_t  ac3_reg [3];
    diff_t  bc3_reg [3];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            d3_reg[j] <= PW'(pr2_reg[j][0]) + PW'(pr2_reg[j][1]) + PW'(pr2_reg[j][2]);
        end
        for (int k = 0; k < 3; k++)
        begin
            a3_reg[k]  <= a2_reg[k];
            b3_reg[k]  <= b2_reg[k];
            c3_reg[k]  <= c2_reg[k];
            ab3_reg[k] <= ab2_reg[k];
            ac3_reg[k] <= ac2_reg[k];
            bc3_reg[k] <= bc2_reg[k];
        end
    end

    // stage 4a: partial products of the cross terms, each operand split into halves
    dot_t px_pp [6];
    dot_t py_pp [6];

    always_comb
    begin
        px_pp[0] = d3_reg[0];
        py_pp[0] = d3_reg[3];
        px_pp[1] = d3_reg[2];
        py_pp[1] = d3_reg[1];
        px_pp[2] = d3_reg[4];
        py_pp[2] = d3_reg[1];
        px_pp[3] = d3_reg[0];
        py_pp[3] = d3_reg[5];
        px_pp[4] = d3_reg[2];
        py_pp[4] = d3_reg[5];
        px_pp[5] = d3_reg[4];
        py_pp[5] = d3_reg[3];
    end

    logic signed [PW-1:0] hh_pp_reg [6];
    logic signed [PW:0]   hl_pp_reg [6];
    logic signed [PW:0]   lh_pp_reg [6];
    logic [PW-1:0]        ll_pp_reg [6];
    dot_t   d_pp_reg [6];
    coord_t a_pp_reg [3];
    coord_t b_pp_reg [3];
    coord_t c_pp_reg [3];
    diff_t  ab_pp_reg [3];
    diff_t  ac_pp_reg [3];
    diff_t  bc_pp_reg [3];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            hh_pp_reg[j] <= PW'($signed(px_pp[j][PW-1:HW])) * PW'($signed(py_pp[j][PW-1:HW]));
            hl_pp_reg[j] <= (PW+1)'($signed(px_pp[j][PW-1:HW]))
                          * (PW+1)'($signed({1'b0, py_pp[j][HW-1:0]}));
            lh_pp_reg[j] <= (PW+1)'($signed({1'b0, px_pp[j][HW-1:0]}))
                          * (PW+1)'($signed(py_pp[j][PW-1:HW]));
            ll_pp_reg[j] <= PW'(px_pp[j][HW-1:0]) * PW'(py_pp[j][HW-1:0]);
            d_pp_reg[j]  <= d3_reg[j];
        end
        for (int k = 0; k < 3; k++)
        begin
            a_pp_reg[k]  <= a3_reg[k];
            b_pp_reg[k]  <= b3_reg[k];
            c_pp_reg[k]  <= c3_reg[k];
            ab_pp_reg[k] <= ab3_reg[k];
            ac_pp_reg[k] <= ac3_reg[k];
            bc_pp_reg[k] <= bc3_reg[k];
        end
    end

    // stage 4b: cross products of dot products for va, vb, vc
    logic signed [2*PW-1:0] p4_reg [6];
    dot_t   d4_reg [6];
    coord_t a4_reg [3];
    coord_t b4_reg [3];
    coord_t c4_reg [3];
    diff_t  ab4_reg [3];
    diff_t  ac4_reg [3];
    diff_t  bc4_reg [3];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            p4_reg[j] <= ((2*PW)'(hh_pp_reg[j]) <<< (2*HW))
                       + (((2*PW)'(hl_pp_reg[j]) + (2*PW)'(lh_pp_reg[j])) <<< HW)
                       + (2*PW)'(ll_pp_reg[j]);
            d4_reg[j] <= d_pp_reg[j];
        end
        for (int k = 0; k < 3; k++)
        begin
            a4_reg[k]  <= a_pp_reg[k];
            b4_reg[k]  <= b_pp_reg[k];
            c4_reg[k]  <= c_pp_reg[k];
            ab4_reg[k] <= ab_pp_reg[k];
            ac4_reg[k] <= ac_pp_reg[k];
            bc4_reg[k] <= bc_pp_reg[k];
        end
    end

    // stage 5: region decision, pick base, multipliers and divisor
    bary_t  va;
    bary_t  vb;
    bary_t  vc;
    logic signed [PW:0] e1;
    logic signed [PW:0] e2;
    numer_t tden;
    coord_t base5_next [3];
    bary_t  m1_5_next;
    bary_t  m2_5_next;
    diff_t  vec1_5_next [3];
    diff_t  vec2_5_next [3];
    numer_t den5_next;
    region_t region5_next;
    logic   degen5_next;

    always_comb
    begin
        vc = VW'(p4_reg[0]) - VW'(p4_reg[1]);
        vb = VW'(p4_reg[2]) - VW'(p4_reg[3]);
        va = VW'(p4_reg[4]) - VW'(p4_reg[5]);
        e1 = (PW+1)'(d4_reg[3]) - (PW+1)'(d4_reg[2]);
        e2 = (PW+1)'(d4_reg[4]) - (PW+1)'(d4_reg[5]);
        tden = '0;
        for (int k = 0; k < 3; k++)
        begin
            base5_next[k]  = a4_reg[k];
            vec1_5_next[k] = ab4_reg[k];
            vec2_5_next[k] = ac4_reg[k];
        end
        m1_5_next    = '0;
        m2_5_next    = '0;
        den5_next    = NW'(1);
        region5_next = REGION_A;
        degen5_next  = 1'b0;
        // vertex and degenerate cases keep zero multipliers so the quotient is zero
        priority if (d4_reg[0] <= 0 && d4_reg[1] <= 0)
        begin
            region5_next = REGION_A;
        end
        else if (d4_reg[2] >= 0 && e1 <= 0)
        begin
            region5_next = REGION_B;
            for (int k = 0; k < 3; k++)
            begin
                base5_next[k] = b4_reg[k];
            end
        end
        else if (vc <= 0 && d4_reg[0] >= 0 && d4_reg[2] <= 0)
        begin
            tden = NW'(d4_reg[0]) - NW'(d4_reg[2]);
            if (tden == 0)
            begin
                degen5_next = 1'b1;
            end
            else
            begin
                region5_next = REGION_AB;
                m1_5_next    = VW'(d4_reg[0]);
                den5_next    = tden;
            end
        end
        else if (d4_reg[5] >= 0 && e2 <= 0)
        begin
            region5_next = REGION_C;
            for (int k = 0; k < 3; k++)
            begin
                base5_next[k] = c4_reg[k];
            end
        end
        else if (vb <= 0 && d4_reg[1] >= 0 && d4_reg[5] <= 0)
        begin
            tden = NW'(d4_reg[1]) - NW'(d4_reg[5]);
            if (tden == 0)
            begin
                degen5_next = 1'b1;
            end
            else
            begin
                region5_next = REGION_AC;
                m1_5_next    = VW'(d4_reg[1]);
                den5_next    = tden;
                for (int k = 0; k < 3; k++)
                begin
                    vec1_5_next[k] = ac4_reg[k];
                end
            end
        end
        else if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            tden = NW'(e1) + NW'(e2);
            if (tden == 0)
            begin
                degen5_next = 1'b1;
            end
            else
            begin
                region5_next = REGION_BC;
                m1_5_next    = VW'(e1);
                den5_next    = tden;
                for (int k = 0; k < 3; k++)
                begin
                    base5_next[k]  = b4_reg[k];
                    vec1_5_next[k] = bc4_reg[k];
                end
            end
        end
        else
        begin
            tden = NW'(va) + NW'(vb) + NW'(vc);
            if (tden == 0)
            begin
                degen5_next = 1'b1;
            end
            else
            begin
                region5_next = REGION_IN;
                m1_5_next    = vb;
                m2_5_next    = vc;
                den5_next    = tden;
            end
        end
    end

    coord_t  base5_reg [3];
    bary_t   m1_5_reg;
    bary_t   m2_5_reg;
    diff_t   vec1_5_reg [3];
    diff_t   vec2_5_reg [3];
    numer_t  den5_reg;
    region_t region5_reg;
    logic    degen5_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            base5_reg[k]  <= base5_next[k];
            vec1_5_reg[k] <= vec1_5_next[k];
            vec2_5_reg[k] <= vec2_5_next[k];
        end
        m1_5_reg    <= m1_5_next;
        m2_5_reg    <= m2_5_next;
        den5_reg    <= den5_next;
        region5_reg <= region5_next;
        degen5_reg  <= degen5_next;
    end

    // stage 6a: limb products; lower limbs unsigned, top limb carries the sign
    logic signed [NL*LW-1:0] m1_ext;
    logic signed [NL*LW-1:0] m2_ext;
    logic signed [LW:0]      m1_limb [NL];
    logic signed [LW:0]      m2_limb [NL];

    always_comb
    begin
        m1_ext = (NL*LW)'(m1_5_reg);
        m2_ext = (NL*LW)'(m2_5_reg);
        for (int i = 0; i < NL - 1; i++)
        begin
            m1_limb[i] = $signed({1'b0, m1_ext[LW*i +: LW]});
            m2_limb[i] = $signed({1'b0, m2_ext[LW*i +: LW]});
        end
        m1_limb[NL-1] = (LW+1)'($signed(m1_ext[NL*LW-1 -: LW]));
        m2_limb[NL-1] = (LW+1)'($signed(m2_ext[NL*LW-1 -: LW]));
    end

    logic signed [LW+DW:0] pp1_reg [NL][3];
    logic signed [LW+DW:0] pp2_reg [NL][3];
    coord_t  base_pp_reg [3];
    numer_t  den_pp_reg;
    region_t region_pp_reg;
    logic    degen_pp_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NL; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pp1_reg[i][k] <= (LW+DW+1)'(m1_limb[i]) * (LW+DW+1)'(vec1_5_reg[k]);
                pp2_reg[i][k] <= (LW+DW+1)'(m2_limb[i]) * (LW+DW+1)'(vec2_5_reg[k]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            base_pp_reg[k] <= base5_reg[k];
        end
        den_pp_reg    <= den5_reg;
        region_pp_reg <= region5_reg;
        degen_pp_reg  <= degen5_reg;
    end

    // stage 6b: numerator products assembled from the limbs
    numer_t  n1_6_next [3];
    numer_t  n2_6_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n1_6_next[k] = '0;
            n2_6_next[k] = '0;
            for (int i = 0; i < NL; i++)
            begin
                n1_6_next[k] = n1_6_next[k] + (NW'(pp1_reg[i][k]) <<< (LW * i));
                n2_6_next[k] = n2_6_next[k] + (NW'(pp2_reg[i][k]) <<< (LW * i));
            end
        end
    end

    numer_t  n1_6_reg [3];
    numer_t  n2_6_reg [3];
    coord_t  base6_reg [3];
    numer_t  den6_reg;
    region_t region6_reg;
    logic    degen6_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            n1_6_reg[k]  <= n1_6_next[k];
            n2_6_reg[k]  <= n2_6_next[k];
            base6_reg[k] <= base_pp_reg[k];
        end
        den6_reg    <= den_pp_reg;
        region6_reg <= region_pp_reg;
        degen6_reg  <= degen_pp_reg;
    end

    // stage 7: numerator sum
    numer_t  num7_reg [3];
    coord_t  base7_reg [3];
    numer_t  den7_reg;
    region_t region7_reg;
    logic    degen7_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num7_reg[k]  <= n1_6_reg[k] + n2_6_reg[k];
            base7_reg[k] <= base6_reg[k];
        end
        den7_reg    <= den6_reg;
        region7_reg <= region6_reg;
        degen7_reg  <= degen6_reg;
    end

    // stage 8: magnitudes; round to nearest as floor((2|n| + |d|) / (2|d|))
    logic [NW-1:0] an8 [3];
    logic [NW-1:0] ad8;

    always_comb
    begin
        ad8 = den7_reg[NW-1] ? NW'(-den7_reg) : NW'(den7_reg);
        for (int k = 0; k < 3; k++)
        begin
            an8[k] = num7_reg[k][NW-1] ? NW'(-num7_reg[k]) : NW'(num7_reg[k]);
        end
    end

    logic [RW-1:0] r8_reg [3];
    logic [RW-1:0] d8_reg;
    logic          neg8_reg [3];
    coord_t        base8_reg [3];
    region_t       region8_reg;
    logic          degen8_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            r8_reg[k]    <= RW'({an8[k], 1'b0}) + RW'(ad8);
            neg8_reg[k]  <= num7_reg[k][NW-1] ^ den7_reg[NW-1];
            base8_reg[k] <= base7_reg[k];
        end
        d8_reg      <= RW'({ad8, 1'b0});
        region8_reg <= region7_reg;
        degen8_reg  <= degen7_reg;
    end

    // divider: entry 0 flags quotients that cannot fit, entries 1..QW take one bit each
    logic [SW-1:0] dr_reg  [QW+1][3];
    logic [QW-1:0] dq_reg  [QW+1][3];
    logic          dov_reg [QW+1][3];
    logic          dn_reg  [QW+1][3];
    coord_t        db_reg  [QW+1][3];
    logic [RW-1:0] dd_reg  [QW+1];
    region_t       dg_reg  [QW+1];
    logic          dz_reg  [QW+1];
    logic [QW:0]   dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else
        begin
            dv_reg <= {dv_reg[QW-1:0], v_reg[10]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            dr_reg[0][k]  <= SW'(r8_reg[k]);
            dq_reg[0][k]  <= '0;
            dov_reg[0][k] <= SW'(r8_reg[k]) >= (SW'(d8_reg) << QW);
            dn_reg[0][k]  <= neg8_reg[k];
            db_reg[0][k]  <= base8_reg[k];
        end
        dd_reg[0] <= d8_reg;
        dg_reg[0] <= region8_reg;
        dz_reg[0] <= degen8_reg;
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        localparam int BI = QW - j;
        logic [SW-1:0] trial;
        logic          fit [3];

        always_comb
        begin
            trial = SW'(dd_reg[j-1]) << BI;
            for (int k = 0; k < 3; k++)
            begin
                fit[k] = dr_reg[j-1][k] >= trial;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dr_reg[j][k]  <= fit[k] ? dr_reg[j-1][k] - trial : dr_reg[j-1][k];
                dq_reg[j][k]  <= dq_reg[j-1][k] | (fit[k] ? (QW'(1) << BI) : '0);
                dov_reg[j][k] <= dov_reg[j-1][k];
                dn_reg[j][k]  <= dn_reg[j-1][k];
                db_reg[j][k]  <= db_reg[j-1][k];
            end
            dd_reg[j] <= dd_reg[j-1];
            dg_reg[j] <= dg_reg[j-1];
            dz_reg[j] <= dz_reg[j-1];
        end
    end

    // output: apply sign, add base, saturate
    logic [QW-1:0]      mag [3];
    logic signed [OW-1:0] sum [3];
    coord_t             sat_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = dov_reg[QW][k] ? '1 : dq_reg[QW][k];
            sum[k] = dn_reg[QW][k] ? OW'(db_reg[QW][k]) - OW'(mag[k])
                                   : OW'(db_reg[QW][k]) + OW'(mag[k]);
            // hold the bound when the upper bits disagree with the coordinate sign
            if (sum[k][OW-1:CW-1] == '0 || sum[k][OW-1:CW-1] == '1)
            begin
                sat_next[k] = sum[k][CW-1:0];
            end
            else if (sum[k][OW-1])
            begin
                sat_next[k] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                sat_next[k] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.nearest_x  <= sat_next[0];
        result_reg.nearest_y  <= sat_next[1];
        result_reg.nearest_z  <= sat_next[2];
        result_reg.region     <= dg_reg[QW];
        result_reg.degenerate <= dz_reg[QW];
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("transaction did not complete after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a matching accepted transaction");

    a_degen_region: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |-> (result.region == REGION_A))
        else $error("degenerate result must report vertex a");

endmodule
